/* hw/rtl/sls_pkg.sv */
package sls_pkg;

    // Width of the size registers and of the result fields.
    localparam int CFG_W    = 11;
    localparam int DOWN_W   = 21;
    localparam int BORDER_W = 12;
    localparam int UNLIKE_W = 22;
    localparam int PAIRS_W  = 21;

    // Stream widths: the input spin sits in bit 0 of one byte; the result
    // packs down_count, border_down_count and unlike_pairs from bit 0 up.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_FIELD_W = DOWN_W + BORDER_W + PAIRS_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Register map.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Position information of one cell, handed from the scan stage to the
    // accumulate stage.
    typedef struct packed {
        logic spin;
        logic first_col;
        logic first_row;
        logic border;
        logic lattice_end;
    } sls_cell_t;

endpackage

/* hw/rtl/sls_ram.sv */
module sls_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/sls_scan.sv */
module sls_scan #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sls_pkg::CFG_W-1:0]     rows,
    input  logic [sls_pkg::CFG_W-1:0]     cols,
    input  logic                          accept,
    input  logic                          spin,
    output logic [$clog2(MAX_COLS)-1:0]   col_addr,
    output sls_pkg::sls_cell_t            scan_info
);

    import sls_pkg::*;

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int RSW = ((CFG_W > RW + 1) ? CFG_W : RW + 1) + 1;
    localparam int CSW = ((CFG_W > CW + 1) ? CFG_W : CW + 1) + 1;

    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [RSW-1:0] rows_ext, nr_m1;
    logic [CSW-1:0] cols_ext, nc_m1;
    logic           last_col, last_row;

    // Sizes below two act as two, sizes above the maximum act as the maximum.
    always_comb
    begin
        rows_ext = RSW'(rows);
        cols_ext = CSW'(cols);
        if (rows_ext < RSW'(2))
        begin
            nr_m1 = RSW'(1);
        end
        else if (rows_ext > RSW'(MAX_ROWS))
        begin
            nr_m1 = RSW'(MAX_ROWS - 1);
        end
        else
        begin
            nr_m1 = rows_ext - RSW'(1);
        end
        if (cols_ext < CSW'(2))
        begin
            nc_m1 = CSW'(1);
        end
        else if (cols_ext > CSW'(MAX_COLS))
        begin
            nc_m1 = CSW'(MAX_COLS - 1);
        end
        else
        begin
            nc_m1 = cols_ext - CSW'(1);
        end
    end

    assign last_col = CSW'(col_reg) >= nc_m1;
    assign last_row = RSW'(row_reg) >= nr_m1;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (!last_col)
            begin
                col_next = col_reg + CW'(1);
            end
            else
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col_addr = col_reg;

    always_comb
    begin
        scan_info.spin        = spin;
        scan_info.first_col   = (col_reg == '0);
        scan_info.first_row   = (row_reg == '0);
        scan_info.border      = (col_reg == '0) || (row_reg == '0) || last_col || last_row;
        scan_info.lattice_end = last_col && last_row;
    end

endmodule

/* hw/rtl/sls_accum.sv */
module sls_accum #(
    parameter int AW = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  sls_pkg::sls_cell_t               scan_info,
    input  logic [AW-1:0]                    col_addr,
    input  logic                             above_spin,
    output logic                             stage_ready,
    output logic                             wr_en,
    output logic [AW-1:0]                    wr_addr,
    output logic                             wr_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [sls_pkg::DOWN_W-1:0]       down_count,
    output logic [sls_pkg::BORDER_W-1:0]     border_down_count,
    output logic [sls_pkg::PAIRS_W-1:0]      unlike_pairs
);

    import sls_pkg::*;

    logic               s1_valid_reg, s1_valid_next;
    sls_cell_t          s1_cell_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic               left_reg;
    logic [DOWN_W-1:0]   down_reg, down_next, down_sum;
    logic [BORDER_W-1:0] border_reg, border_next, border_sum;
    logic [UNLIKE_W-1:0] unlike_reg, unlike_next, unlike_sum;
    logic               out_valid_reg, out_valid_next;
    logic [DOWN_W-1:0]   out_down_reg;
    logic [BORDER_W-1:0] out_border_reg;
    logic [PAIRS_W-1:0]  out_unlike_reg;
    logic               stall, fire, h_diff, v_diff;

    // A finished lattice can only leave the stage when the result register is free.
    assign stall = s1_valid_reg && s1_cell_reg.lattice_end && out_valid_reg && !out_ready;
    assign fire  = s1_valid_reg && !stall;
    assign stage_ready = !stall;

    assign h_diff = !s1_cell_reg.first_col && (left_reg != s1_cell_reg.spin);
    assign v_diff = !s1_cell_reg.first_row && (above_spin != s1_cell_reg.spin);

    always_comb
    begin
        down_sum   = down_reg + DOWN_W'(s1_cell_reg.spin);
        border_sum = border_reg + BORDER_W'(s1_cell_reg.spin && s1_cell_reg.border);
        unlike_sum = unlike_reg + UNLIKE_W'(h_diff) + UNLIKE_W'(v_diff);
        down_next   = down_reg;
        border_next = border_reg;
        unlike_next = unlike_reg;
        if (fire)
        begin
            if (s1_cell_reg.lattice_end)
            begin
                down_next   = '0;
                border_next = '0;
                unlike_next = '0;
            end
            else
            begin
                down_next   = down_sum;
                border_next = border_sum;
                unlike_next = unlike_sum;
            end
        end
        s1_valid_next = stall ? s1_valid_reg : accept;
        if (fire && s1_cell_reg.lattice_end)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            left_reg      <= 1'b0;
            down_reg      <= '0;
            border_reg    <= '0;
            unlike_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            down_reg      <= down_next;
            border_reg    <= border_next;
            unlike_reg    <= unlike_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                left_reg <= s1_cell_reg.spin;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cell_reg <= scan_info;
            s1_addr_reg <= col_addr;
        end
        if (fire && s1_cell_reg.lattice_end)
        begin
            out_down_reg   <= down_sum;
            out_border_reg <= border_sum;
            out_unlike_reg <= unlike_sum[PAIRS_W-1:0];
        end
    end

    assign wr_en             = fire;
    assign wr_addr           = s1_addr_reg;
    assign wr_data           = s1_cell_reg.spin;
    assign out_valid         = out_valid_reg;
    assign down_count        = out_down_reg;
    assign border_down_count = out_border_reg;
    assign unlike_pairs      = out_unlike_reg;

endmodule

/* hw/rtl/spin_lattice_statistics_unit.sv */
// Spin lattice statistics unit.
// The input stream (s_axis_*) carries one lattice cell per request in raster
// order; s_axis_tdata[0] is 1 for a down spin. For every lattice the unit
// counts the down spins, the down spins on the border and the adjacent pairs
// with differing spins. After the last cell it sends one request on the output
// stream (m_axis_*) with the three totals and clears its counters.
// The lattice size comes from the rows and cols registers on the APB port;
// they are to be written only while no lattice is in flight, which the unit
// does not enforce. Throughput is one cell per clock while s_axis_tready is
// high. The previous row is kept in a one-bit line store RAM: a cell's read is
// issued in its acceptance cycle and registered with the cell; the compare,
// write back and, for the last cell, the result load run as it leaves that stage.
// The result sits in an output register; new cells are accepted while it
// waits. Only when another lattice completes before the previous result was
// taken does s_axis_tready drop until the output register frees.
// Reset clears the position, the counters and the output; rows and cols
// return to their maximum. The line store is not cleared, since every entry
// is written before it is read within a lattice.
module spin_lattice_statistics_unit #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sls_pkg::PADDR_W-1:0]       paddr,
    input  logic [sls_pkg::PDATA_W-1:0]       pwdata,
    output logic [sls_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    // Input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sls_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [0] spin_down
    // Output stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [20:0] down_count, [32:21] border_down_count, [53:33] unlike_pairs
    output logic [sls_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    import sls_pkg::*;

    localparam int AW = $clog2(MAX_COLS);
    localparam int CFG_MAX = (1 << CFG_W) - 1;
    localparam logic [CFG_W-1:0] ROWS_RESET =
        CFG_W'((MAX_ROWS > CFG_MAX) ? CFG_MAX : MAX_ROWS);
    localparam logic [CFG_W-1:0] COLS_RESET =
        CFG_W'((MAX_COLS > CFG_MAX) ? CFG_MAX : MAX_COLS);

    logic [CFG_W-1:0]    rows_reg, cols_reg;
    logic                cfg_write;
    logic                accept, stage_ready, above_spin;
    logic [AW-1:0]       col_addr, wr_addr;
    logic                wr_en, wr_data;
    sls_cell_t           scan_info;
    logic [DOWN_W-1:0]   down_count;
    logic [BORDER_W-1:0] border_down_count;
    logic [PAIRS_W-1:0]  unlike_pairs;

    // Register file: rows at byte address 0, cols at byte address 4.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_ROWS)
            begin
                rows_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                cols_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_COLS) ? PDATA_W'(cols_reg) : PDATA_W'(rows_reg);

    assign s_axis_tready = stage_ready;
    assign accept        = s_axis_tvalid && stage_ready;

    // Position tracking and border classification of the incoming cell.
    sls_scan #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .rows      (rows_reg),
        .cols      (cols_reg),
        .accept    (accept),
        .spin      (s_axis_tdata[0]),
        .col_addr  (col_addr),
        .scan_info (scan_info)
    );

    // Line store holding the spins of the row above the current cell.
    sls_ram #(
        .WIDTH (1),
        .DEPTH (MAX_COLS)
    ) u_line (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (col_addr),
        .rd_data (above_spin)
    );

    // Compare against the neighbors, update the counters, hold the result.
    sls_accum #(
        .AW (AW)
    ) u_accum (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .scan_info         (scan_info),
        .col_addr          (col_addr),
        .above_spin        (above_spin),
        .stage_ready       (stage_ready),
        .wr_en             (wr_en),
        .wr_addr           (wr_addr),
        .wr_data           (wr_data),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .down_count        (down_count),
        .border_down_count (border_down_count),
        .unlike_pairs      (unlike_pairs)
    );

    assign m_axis_tdata = OUT_TDATA_W'({unlike_pairs, border_down_count, down_count});

endmodule
